[rtl/stcl_pkg.sv]
// Package for the scaled tick line counter: widths, constants, codes and types.
// Used by the divider, the multiplier and the top level; depends on nothing.
`default_nettype none

package stcl_pkg;

  // Fraction bits of the line count
  localparam int FRAC_BITS  = 16;
  localparam int HZ_SHIFT   = FRAC_BITS - 3;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SPEED_W    = 12;
  localparam int LINES_W    = 10;
  localparam int HZ_W       = 17;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Span scaling
  localparam int SPEED_SHIFT = 7;                       // divide by 128
  localparam int SPAN_W      = DATA_W - SPEED_SHIFT;
  localparam int CLAMP_W     = 10;
  localparam logic [CLAMP_W-1:0] SPAN_MAX = CLAMP_W'(1000);

  // Divider: 32-bit dividend, narrow divisor
  localparam int DIV_W      = LINES_W;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Divide by 125 as a multiply by a rounded-up reciprocal and a shift;
  // the rounding error stays below one quotient step for any 32-bit dividend
  localparam int MS_DIV         = 1000 >> 3;
  localparam int MS_RECIP_SHIFT = 35;
  localparam logic [DATA_W-1:0] MS_RECIP =
    DATA_W'(((64'd1 << MS_RECIP_SHIFT) + 64'(MS_DIV) - 64'd1) / 64'(MS_DIV));

  // Reset values of the configuration registers
  localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(100);
  localparam logic [LINES_W-1:0] LINES_RST = LINES_W'(440);
  localparam logic [HZ_W-1:0]    HZ_RST    = HZ_W'(24830);

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ADVANCE = 3'd0,
    FN_PEEK    = 3'd1,
    FN_RAW     = 3'd2,
    FN_RESET   = 3'd3,
    FN_SET     = 3'd4,
    FN_STEP    = 3'd5
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED = 2'd0,
    CFG_LINES = 2'd1,
    CFG_HZ    = 2'd2
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LINES,
    S_MUL_STEP,
    S_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

[rtl/stcl_div.sv]
// Restoring divider, one quotient bit per cycle: 32-bit dividend, narrow divisor.
// Depends on stcl_pkg.
`default_nettype none

module stcl_div
  import stcl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W:0]       rem_sh;
  logic                 ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      rem_nxt = ge ? DIV_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/stcl_mul.sv]
// Shared registered multiplier, full 64-bit product of two 32-bit operands.
// Depends on stcl_pkg.
`default_nettype none

module stcl_mul
  import stcl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DATA_W-1:0] op_a,
  input  wire logic [DATA_W-1:0] op_b,
  output logic [PROD_W-1:0]      prod
);

  logic [PROD_W-1:0] prod_r;

  // Capture the full product when enabled, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

[rtl/scaled_tick_line_counter_unit.sv]
// Scaled tick line counter: top level with sequencer, state and result register.
// Depends on stcl_pkg, stcl_div and stcl_mul.
//
// Usage:
//   An item (in_func, in_now_tick, in_new_count) is taken when in_valid and
//   in_ready are both high; every item yields exactly one result item on
//   out_result_value, handed over when out_valid and out_ready are high.
//   in_ready is high only while the sequencer is idle. An item runs through a
//   32-step pass of the shared divider (scan rate by line count), then the
//   shared multiplier divides the quotient by 125 through a reciprocal, then
//   it multiplies span times step, and a last step updates state and loads the
//   result. The span product runs on the multiplier during acceptance.
//   Items are therefore taken only after the previous one has finished.
//   The result sits in an output register; a new item may be accepted while
//   it waits. If the receiver stalls, the next item holds in its final cycle
//   until the output register frees up, and no state is updated before then.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
//   the user must write them only while the block is idle, which the block
//   itself leaves unchecked; an unknown index is ignored.
//   A synchronous reset (rst_n low) restores the configuration defaults,
//   clears tick, count and fraction, and empties the output register.
`default_nettype none

module scaled_tick_line_counter_unit
  import stcl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [DATA_W-1:0]     in_now_tick,
  input  wire logic [DATA_W-1:0]     in_new_count,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_W-1:0]          out_result_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration
  logic [SPEED_W-1:0] speed_r;
  logic [LINES_W-1:0] lines_r;
  logic [HZ_W-1:0]    hz_r;

  // Architectural state
  logic [DATA_W-1:0]    last_tick_r, last_tick_nxt;
  logic [DATA_W-1:0]    frame_r, frame_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;

  // Sequencer and item registers
  seq_state_t         state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r;
  logic [DATA_W-1:0]  now_r;
  logic [DATA_W-1:0]  nc_r;
  logic [SPAN_W-1:0]  span_r;
  logic [DATA_W-1:0]  step_r;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;

  // Shared units
  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  div_dividend;
  logic [DIV_W-1:0]   div_divisor;
  logic [DATA_W-1:0]  div_quo;
  logic               mul_en;
  logic [DATA_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic               in_acc;
  logic               out_free;
  logic               span_nz;
  logic [CLAMP_W-1:0] clamped;
  logic [DATA_W-1:0]  step_now;
  logic [DATA_W-1:0]  acc;
  logic [DATA_W-1:0]  carried;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign span_nz  = span_r != '0;
  assign clamped  = (span_r >= SPAN_W'(SPAN_MAX)) ? SPAN_MAX : span_r[CLAMP_W-1:0];
  assign step_now = DATA_W'(mul_p[PROD_W-1:MS_RECIP_SHIFT]);
  assign acc      = DATA_W'(frac_r) + mul_p[DATA_W-1:0];
  assign carried  = frame_r + (acc >> FRAC_BITS);

  stcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  stcl_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // Sequencer: next state, unit control and state update
  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    div_dividend  = DATA_W'(hz_r) << HZ_SHIFT;
    div_divisor   = (lines_r == '0) ? DIV_W'(1) : lines_r;
    mul_en        = 1'b0;
    mul_a         = in_now_tick - last_tick_r;
    mul_b         = DATA_W'(speed_r);
    last_tick_nxt = last_tick_r;
    frame_nxt     = frame_r;
    frac_nxt      = frac_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          mul_en    = 1'b1;
          state_nxt = S_DIV_LINES;
        end
      end
      S_DIV_LINES: begin
        // Divide the quotient by 125 through the reciprocal
        if (div_done) begin
          mul_en    = 1'b1;
          mul_a     = div_quo;
          mul_b     = MS_RECIP;
          state_nxt = S_MUL_STEP;
        end
      end
      S_MUL_STEP: begin
        mul_en    = 1'b1;
        mul_a     = DATA_W'(clamped);
        mul_b     = step_now;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
          unique case (func_r)
            FN_ADVANCE: begin
              if (span_nz) begin
                last_tick_nxt = now_r;
                frame_nxt     = carried;
                frac_nxt      = acc[FRAC_BITS-1:0];
                out_data_nxt  = carried;
              end else begin
                out_data_nxt  = frame_r;
              end
            end
            FN_PEEK: begin
              out_data_nxt = span_nz ? carried : '0;
            end
            FN_RAW: begin
              out_data_nxt = (frame_r << FRAC_BITS) + acc;
            end
            FN_RESET: begin
              last_tick_nxt = now_r;
              frame_nxt     = '0;
              frac_nxt      = '0;
            end
            FN_SET: begin
              frame_nxt = nc_r;
            end
            FN_STEP: begin
              out_data_nxt = step_r;
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_tick_r <= '0;
      frame_r     <= '0;
      frac_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_tick_r <= last_tick_nxt;
      frame_r     <= frame_nxt;
      frac_r      <= frac_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RST;
      lines_r <= LINES_RST;
      hz_r    <= HZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPEED: speed_r <= cfg_wdata[SPEED_W-1:0];
        CFG_LINES: lines_r <= cfg_wdata[LINES_W-1:0];
        CFG_HZ:    hz_r    <= cfg_wdata[HZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item payload, span and step captures
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      now_r  <= in_now_tick;
      nc_r   <= in_new_count;
    end
    if (state_r == S_DIV_LINES && div_done) begin
      span_r <= mul_p[DATA_W-1:SPEED_SHIFT];
    end
    if (state_r == S_MUL_STEP) begin
      step_r <= step_now;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_data_r;

endmodule

`default_nettype wire

[rtl/stcl_chk.sv]
// Port-level checker for the scaled tick line counter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module stcl_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result_value
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("stalled result changed or dropped");

  // Go busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was taken");

  // No result appears right after an item is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 !$rose(out_valid))
    else $error("result appeared too early");

  // Reset empties the output and makes the input ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind scaled_tick_line_counter_unit stcl_chk u_stcl_chk (.*);

`default_nettype wire
